/* src/ppas_pkg.sv */
// Shared types and constants for the preemptive priority aging scheduler.
package ppas_pkg;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_TICK = 1'b1;

    localparam logic CFG_PROCESS_COUNT = 1'b0;
    localparam logic CFG_AGING_PERIOD  = 1'b1;

    localparam logic [3:0] PROCESS_COUNT_RESET = 4'd3;
    localparam logic [7:0] AGING_PERIOD_RESET  = 8'd5;

    typedef struct packed {
        logic        opcode;
        logic [2:0]  slot_index;
        logic [15:0] arrival;
        logic [15:0] burst;
        logic [7:0]  start_priority;
    } in_t;

    typedef struct packed {
        logic        all_done;
        logic        idle;
        logic [2:0]  running_slot;
        logic        preempted;
        logic        completed;
        logic [31:0] turnaround;
        logic [31:0] tick_time;
        logic [7:0]  aged_mask;
        logic [31:0] idle_total;
    } out_t;

    typedef struct packed {
        logic [15:0] arrival;
        logic [15:0] burst;
        logic [15:0] remaining;
        logic [7:0]  prio;
    } slot_t;

    localparam int SLOT_W = $bits(slot_t);

endpackage

/* src/preemptive_priority_aging_scheduler.sv */
// Top level: preemptive priority scheduler with aging, one slot visited per step.
// Load beat: written to the slot RAM, no result. All-done tick: scan, then result beat.
// Tick beat: scan, serve and aging pass over the n slots in use, then the result beat; an
// aging candidate's waiting time goes through the shared 4-bit-per-cycle remainder unit.
// One tick at a time; the slot RAM read port sets the scan rate (read, then check, per slot).
// Reset (rst_n, async low) clears control state; slot RAM contents stay undefined.
module preemptive_priority_aging_scheduler
    import ppas_pkg::*;
#(
    parameter int MAX_SLOTS = 8
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  in_t        in_data,
    output logic       out_valid,
    input  logic       out_stall,
    output out_t       out_data,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_index,
    input  logic [7:0] cfg_data
);

    localparam int SW = $clog2(MAX_SLOTS);
    localparam int NW = $clog2(MAX_SLOTS + 1);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_SCAN_RD  = 4'd1;
    localparam logic [3:0] S_SCAN_CHK = 4'd2;
    localparam logic [3:0] S_SERVE    = 4'd3;
    localparam logic [3:0] S_AGE_RD   = 4'd4;
    localparam logic [3:0] S_AGE_CHK  = 4'd5;
    localparam logic [3:0] S_AGE_DIV  = 4'd6;
    localparam logic [3:0] S_AGE_WR   = 4'd7;
    localparam logic [3:0] S_PUT      = 4'd8;

    logic [3:0]           state_reg, state_next;
    logic [NW-1:0]        idx_reg, idx_next;
    logic [MAX_SLOTS-1:0] fin_reg, fin_next;
    logic [31:0]          time_reg, time_next;
    logic [SW-1:0]        prev_reg, prev_next;
    logic                 first_reg, first_next;
    logic [31:0]          idle_cnt_reg, idle_cnt_next;
    logic [3:0]           pc_reg, pc_next;
    logic [7:0]           ap_reg, ap_next;
    logic [SW-1:0]        sel_reg, sel_next;
    logic                 found_reg, found_next;
    logic                 have_unf_reg, have_unf_next;
    logic [SW-1:0]        first_unf_reg, first_unf_next;
    logic [MAX_SLOTS-1:0] aged_reg, aged_next;
    logic [2:0]           div_cnt_reg, div_cnt_next;
    logic                 out_valid_reg, out_valid_next;

    slot_t                sel_word_reg, sel_word_next;
    slot_t                age_word_reg, age_word_next;
    logic [31:0]          div_reg, div_next;
    logic [7:0]           rem_reg, rem_next;
    out_t                 res_reg, res_next;
    out_t                 out_reg, out_next;

    logic                 ram_we;
    logic [SW-1:0]        ram_waddr;
    slot_t                ram_wdata;
    logic [SLOT_W-1:0]    ram_rdata;
    slot_t                rd_slot;

    logic [NW-1:0]        n_slots;
    logic [SW-1:0]        idx_s;
    logic [SW+2:0]        ld_ext;
    logic                 ld_ok;
    logic [SW+2:0]        sel_ext;
    logic [MAX_SLOTS+7:0] aged_ext;

    assign rd_slot  = slot_t'(ram_rdata);
    assign idx_s    = idx_reg[SW-1:0];
    assign ld_ext   = {{SW{1'b0}}, in_data.slot_index};
    assign ld_ok    = 32'(in_data.slot_index) < 32'(MAX_SLOTS);
    assign sel_ext  = {3'b000, sel_reg};
    assign aged_ext = {8'h00, aged_reg};

    always_comb
    begin
        if (32'(pc_reg) > 32'(MAX_SLOTS))
        begin
            n_slots = NW'(MAX_SLOTS);
        end
        else
        begin
            n_slots = NW'(pc_reg);
        end
    end

    ppas_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (MAX_SLOTS)
    ) u_slot_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (idx_s),
        .rdata (ram_rdata)
    );

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign cfg_ready = 1'b1;

    always_comb
    begin
        logic [8:0]  r9;
        logic [7:0]  r8;
        logic [31:0] d;
        logic [15:0] served;
        logic [31:0] wait_time;
        logic [15:0] rem_dec;
        logic        elig;
        logic        skip;

        state_next     = state_reg;
        idx_next       = idx_reg;
        fin_next       = fin_reg;
        time_next      = time_reg;
        prev_next      = prev_reg;
        first_next     = first_reg;
        idle_cnt_next  = idle_cnt_reg;
        pc_next        = pc_reg;
        ap_next        = ap_reg;
        sel_next       = sel_reg;
        found_next     = found_reg;
        have_unf_next  = have_unf_reg;
        first_unf_next = first_unf_reg;
        aged_next      = aged_reg;
        div_cnt_next   = div_cnt_reg;
        out_valid_next = out_valid_reg;
        sel_word_next  = sel_word_reg;
        age_word_next  = age_word_reg;
        div_next       = div_reg;
        rem_next       = rem_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        ram_we         = 1'b0;
        ram_waddr      = idx_s;
        ram_wdata      = rd_slot;

        r8 = rem_reg;
        d  = div_reg;
        r9 = 9'd0;
        for (int k = 0; k < 4; k++)
        begin
            r9 = {r8, d[31]};
            d  = {d[30:0], 1'b0};
            if (r9 >= {1'b0, ap_reg})
            begin
                r9 = r9 - {1'b0, ap_reg};
            end
            r8 = r9[7:0];
        end

        served    = rd_slot.burst - rd_slot.remaining;
        wait_time = time_reg - 32'(rd_slot.arrival) - 32'(served) + 32'd1;
        elig      = !fin_reg[idx_s] && ({16'h0000, rd_slot.arrival} <= time_reg);
        skip      = found_reg && (idx_s == sel_reg);
        rem_dec   = sel_word_reg.remaining - 16'd1;

        if (cfg_valid)
        begin
            if (cfg_index == CFG_PROCESS_COUNT)
            begin
                pc_next = cfg_data[3:0];
            end
            else
            begin
                ap_next = cfg_data;
            end
        end

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (in_data.opcode == OP_LOAD)
                    begin
                        if (ld_ok)
                        begin
                            ram_we    = 1'b1;
                            ram_waddr = ld_ext[SW-1:0];
                            ram_wdata = '{arrival:   in_data.arrival,
                                          burst:     in_data.burst,
                                          remaining: in_data.burst,
                                          prio:      in_data.start_priority};
                            fin_next[ld_ext[SW-1:0]] = 1'b0;
                            if (in_data.slot_index == 3'd0)
                            begin
                                time_next     = 32'(in_data.arrival);
                                fin_next      = '0;
                                prev_next     = '0;
                                first_next    = 1'b1;
                                idle_cnt_next = '0;
                            end
                        end
                    end
                    else
                    begin
                        idx_next       = '0;
                        found_next     = 1'b0;
                        have_unf_next  = 1'b0;
                        sel_next       = '0;
                        first_unf_next = '0;
                        state_next     = S_SCAN_RD;
                    end
                end
            end
            S_SCAN_RD:
            begin
                if (idx_reg == n_slots)
                begin
                    state_next = S_SERVE;
                end
                else
                begin
                    state_next = S_SCAN_CHK;
                end
            end
            S_SCAN_CHK:
            begin
                if (!fin_reg[idx_s])
                begin
                    if (!have_unf_reg)
                    begin
                        have_unf_next  = 1'b1;
                        first_unf_next = idx_s;
                    end
                    if (({16'h0000, rd_slot.arrival} <= time_reg) &&
                        (!found_reg || (rd_slot.prio <= sel_word_reg.prio)))
                    begin
                        sel_next      = idx_s;
                        found_next    = 1'b1;
                        sel_word_next = rd_slot;
                    end
                end
                idx_next   = idx_reg + NW'(1);
                state_next = S_SCAN_RD;
            end
            S_SERVE:
            begin
                res_next           = '0;
                res_next.tick_time = time_reg;
                idx_next           = '0;
                aged_next          = '0;
                if (!have_unf_reg)
                begin
                    res_next.all_done   = 1'b1;
                    res_next.idle_total = idle_cnt_reg;
                    state_next          = S_PUT;
                end
                else if (!found_reg)
                begin
                    idle_cnt_next       = idle_cnt_reg + 32'd1;
                    res_next.idle       = 1'b1;
                    res_next.idle_total = idle_cnt_reg + 32'd1;
                    sel_next            = first_unf_reg;
                    prev_next           = first_unf_reg;
                    state_next          = S_AGE_RD;
                end
                else
                begin
                    ram_we                = 1'b1;
                    ram_waddr             = sel_reg;
                    ram_wdata             = sel_word_reg;
                    ram_wdata.remaining   = rem_dec;
                    res_next.running_slot = sel_ext[2:0];
                    res_next.preempted    = (sel_reg != prev_reg) && !first_reg;
                    res_next.idle_total   = idle_cnt_reg;
                    first_next            = 1'b0;
                    prev_next             = sel_reg;
                    if (rem_dec == 16'd0)
                    begin
                        fin_next[sel_reg]   = 1'b1;
                        res_next.completed  = 1'b1;
                        res_next.turnaround = time_reg - 32'(sel_word_reg.arrival) + 32'd1;
                    end
                    state_next = S_AGE_RD;
                end
            end
            S_AGE_RD:
            begin
                if (idx_reg == n_slots)
                begin
                    res_next.aged_mask = aged_ext[7:0];
                    time_next          = time_reg + 32'd1;
                    state_next         = S_PUT;
                end
                else
                begin
                    state_next = S_AGE_CHK;
                end
            end
            S_AGE_CHK:
            begin
                if (elig && !skip && (rd_slot.prio > 8'd1) && (ap_reg != 8'd0) &&
                    (wait_time != 32'd0))
                begin
                    age_word_next = rd_slot;
                    div_next      = wait_time;
                    rem_next      = '0;
                    div_cnt_next  = '0;
                    state_next    = S_AGE_DIV;
                end
                else
                begin
                    idx_next   = idx_reg + NW'(1);
                    state_next = S_AGE_RD;
                end
            end
            S_AGE_DIV:
            begin
                div_next     = d;
                rem_next     = r8;
                div_cnt_next = div_cnt_reg + 3'd1;
                if (div_cnt_reg == 3'd7)
                begin
                    state_next = S_AGE_WR;
                end
            end
            S_AGE_WR:
            begin
                if (rem_reg == 8'd0)
                begin
                    ram_we           = 1'b1;
                    ram_wdata        = age_word_reg;
                    ram_wdata.prio   = age_word_reg.prio - 8'd1;
                    aged_next[idx_s] = 1'b1;
                end
                idx_next   = idx_reg + NW'(1);
                state_next = S_AGE_RD;
            end
            S_PUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            idx_reg       <= '0;
            fin_reg       <= '0;
            time_reg      <= '0;
            prev_reg      <= '0;
            first_reg     <= 1'b1;
            idle_cnt_reg  <= '0;
            pc_reg        <= PROCESS_COUNT_RESET;
            ap_reg        <= AGING_PERIOD_RESET;
            sel_reg       <= '0;
            found_reg     <= 1'b0;
            have_unf_reg  <= 1'b0;
            first_unf_reg <= '0;
            aged_reg      <= '0;
            div_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            fin_reg       <= fin_next;
            time_reg      <= time_next;
            prev_reg      <= prev_next;
            first_reg     <= first_next;
            idle_cnt_reg  <= idle_cnt_next;
            pc_reg        <= pc_next;
            ap_reg        <= ap_next;
            sel_reg       <= sel_next;
            found_reg     <= found_next;
            have_unf_reg  <= have_unf_next;
            first_unf_reg <= first_unf_next;
            aged_reg      <= aged_next;
            div_cnt_reg   <= div_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sel_word_reg <= sel_word_next;
        age_word_reg <= age_word_next;
        div_reg      <= div_next;
        rem_reg      <= rem_next;
        res_reg      <= res_next;
        out_reg      <= out_next;
    end

endmodule

/* src/ppas_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module ppas_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* src/ppas_checker.sv */
// Port-level checker for the scheduler, bound to the top level.
module ppas_checker
    import ppas_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input in_t        in_data,
    input logic       out_valid,
    input logic       out_stall,
    input out_t       out_data
);

    a_tick_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && (in_data.opcode == OP_TICK) |=> in_stall)
    else $error("input taken right after a tick beat");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result beat changed or dropped");

    a_done_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.all_done |-> !out_data.idle && !out_data.completed &&
            !out_data.preempted && (out_data.aged_mask == 8'h00) &&
            (out_data.turnaround == 32'd0) && (out_data.running_slot == 3'd0))
    else $error("done beat carries service fields");

    a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.idle |-> !out_data.completed && !out_data.preempted &&
            (out_data.running_slot == 3'd0) && (out_data.turnaround == 32'd0))
    else $error("idle beat carries service fields");

    a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
    else $error("result beat without a tick in progress");

endmodule

bind preemptive_priority_aging_scheduler ppas_checker u_ppas_checker (.*);

/* test/tb.sv */
// Testbench for the preemptive priority aging scheduler: random traffic checked against a predictor.
`timescale 1ns / 1ps

module tb;
    import ppas_pkg::*;

    localparam int SLOTS        = 8;
    localparam int DRAIN_CYCLES = 150;
    localparam int HOLD_CYCLES  = 600;
    localparam int CYCLE_LIMIT  = 1500000;
    localparam int PRINT_LIMIT  = 40;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic       in_stall;
    in_t        in_data   = '0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    out_t       out_data;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic       cfg_index = 1'b0;
    logic [7:0] cfg_data  = '0;

    preemptive_priority_aging_scheduler u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #6 clk = ~clk;

    logic [15:0] slot_arrival [SLOTS];
    logic [15:0] slot_burst   [SLOTS];
    logic [15:0] slot_left    [SLOTS];
    logic [7:0]  slot_prio    [SLOTS];
    logic [7:0]  finished   = '0;
    logic [31:0] now_time   = '0;
    logic [2:0]  last_slot  = '0;
    logic        first_run  = 1'b1;
    logic [31:0] idle_ticks = '0;
    logic [3:0]  proc_count = PROCESS_COUNT_RESET;
    logic [7:0]  age_period = AGING_PERIOD_RESET;

    in_t  pending_beats [$];
    out_t tick_reports  [$];
    int   beats_issued  = 0;
    int   beats_taken   = 0;
    int   error_count   = 0;
    int   gap_left      = 0;
    int   burst_left    = 0;
    int   stall_mode    = 0;
    int   stall_left    = 0;
    logic stall_next;
    logic hold_out      = 1'b0;
    int   hold_requests = 0;
    int   holds_taken   = 0;
    int   cycle_count   = 0;

    task automatic predict_schedule(input in_t beat);
        out_t        rep;
        int          n;
        int          i;
        int          sel;
        int          first_open;
        bit          found;
        bit          any_open;
        logic [31:0] t;
        logic [15:0] done_cnt;
        logic [31:0] served;
        logic [31:0] waited;
        rep = '0;
        if (beat.opcode == OP_LOAD)
        begin
            slot_arrival[beat.slot_index] = beat.arrival;
            slot_burst[beat.slot_index]   = beat.burst;
            slot_left[beat.slot_index]    = beat.burst;
            slot_prio[beat.slot_index]    = beat.start_priority;
            finished[beat.slot_index]     = 1'b0;
            if (beat.slot_index == 3'd0)
            begin
                now_time   = {16'd0, beat.arrival};
                finished   = '0;
                last_slot  = '0;
                first_run  = 1'b1;
                idle_ticks = '0;
            end
            return;
        end
        n = (proc_count > 4'd8) ? SLOTS : int'(proc_count);
        sel = 0;
        first_open = 0;
        found = 1'b0;
        any_open = 1'b0;
        t = now_time;
        for (i = 0; i < n; i++)
        begin
            if (!finished[i])
            begin
                if (!any_open)
                begin
                    any_open = 1'b1;
                    first_open = i;
                end
                if ({16'd0, slot_arrival[i]} <= t && (!found || slot_prio[i] <= slot_prio[sel]))
                begin
                    sel = i;
                    found = 1'b1;
                end
            end
        end
        rep.tick_time = t;
        if (!any_open)
        begin
            rep.all_done = 1'b1;
            rep.idle_total = idle_ticks;
            tick_reports.push_back(rep);
            return;
        end
        if (!found)
        begin
            idle_ticks = idle_ticks + 32'd1;
            rep.idle = 1'b1;
            sel = first_open;
        end
        else
        begin
            rep.running_slot = sel[2:0];
            rep.preempted = (sel[2:0] != last_slot) && !first_run;
            first_run = 1'b0;
            slot_left[sel] = slot_left[sel] - 16'd1;
            if (slot_left[sel] == 16'd0)
            begin
                finished[sel] = 1'b1;
                rep.completed = 1'b1;
                rep.turnaround = t - {16'd0, slot_arrival[sel]} + 32'd1;
            end
        end
        for (i = 0; i < n; i++)
        begin
            if (!finished[i] && {16'd0, slot_arrival[i]} <= t)
            begin
                done_cnt = slot_burst[i] - slot_left[i];
                served = {16'd0, done_cnt};
                waited = t - {16'd0, slot_arrival[i]} - served + 32'd1;
                if (age_period != 8'd0 && waited != 32'd0 &&
                    waited % {24'd0, age_period} == 32'd0 &&
                    slot_prio[i] > 8'd1 && !(found && i == sel))
                begin
                    slot_prio[i] = slot_prio[i] - 8'd1;
                    rep.aged_mask[i] = 1'b1;
                end
            end
        end
        last_slot = sel[2:0];
        now_time = t + 32'd1;
        rep.idle_total = idle_ticks;
        tick_reports.push_back(rep);
    endtask

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        error_count++;
        if (error_count <= PRINT_LIMIT)
            $display("%0t: tick report %s: got %0h, want %0h", $time, field, got, want);
    endtask

    task automatic check_report(input out_t got);
        out_t want;
        if (tick_reports.size() == 0)
        begin
            report_mismatch("beat with no tick pending", '0, '0);
            return;
        end
        want = tick_reports.pop_front();
        if (got.all_done !== want.all_done)
            report_mismatch("all_done", 32'(got.all_done), 32'(want.all_done));
        if (got.idle !== want.idle)
            report_mismatch("idle", 32'(got.idle), 32'(want.idle));
        if (got.running_slot !== want.running_slot)
            report_mismatch("running_slot", 32'(got.running_slot), 32'(want.running_slot));
        if (got.preempted !== want.preempted)
            report_mismatch("preempted", 32'(got.preempted), 32'(want.preempted));
        if (got.completed !== want.completed)
            report_mismatch("completed", 32'(got.completed), 32'(want.completed));
        if (got.turnaround !== want.turnaround)
            report_mismatch("turnaround", got.turnaround, want.turnaround);
        if (got.tick_time !== want.tick_time)
            report_mismatch("tick_time", got.tick_time, want.tick_time);
        if (got.aged_mask !== want.aged_mask)
            report_mismatch("aged_mask", 32'(got.aged_mask), 32'(want.aged_mask));
        if (got.idle_total !== want.idle_total)
            report_mismatch("idle_total", got.idle_total, want.idle_total);
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                predict_schedule(in_data);
                beats_taken++;
            end
            if (!in_valid || !in_stall)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (pending_beats.size() > 0)
                begin
                    in_data <= pending_beats.pop_front();
                    in_valid <= 1'b1;
                    if (burst_left > 0)
                        burst_left--;
                    else
                    begin
                        burst_left = $urandom_range(0, 24);
                        gap_left = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 40)
                                                               : $urandom_range(0, 4);
                    end
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
                check_report(out_data);
            if (stall_left == 0)
            begin
                stall_mode = $urandom_range(0, 3);
                stall_left = $urandom_range(20, 300);
            end
            else
                stall_left--;
            case (stall_mode)
                0: stall_next = 1'b0;
                1: stall_next = ($urandom_range(0, 3) == 0);
                2: stall_next = ($urandom_range(0, 9) < 7);
                default: stall_next = !out_stall;
            endcase
            out_stall <= hold_out || stall_next;
        end
    end

    // hold the result side off so the block backs up into its input
    initial
    begin
        while (1)
        begin
            while (holds_taken == hold_requests)
                @(posedge clk);
            holds_taken++;
            repeat ($urandom_range(40, 300)) @(posedge clk);
            hold_out <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clk);
            hold_out <= 1'b0;
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("*** FAILED ***");
        $finish;
    end

    task automatic push_beat(input logic op, input logic [2:0] slot, input logic [15:0] arr,
                             input logic [15:0] len, input logic [7:0] pr);
        in_t b;
        b.opcode = op;
        b.slot_index = slot;
        b.arrival = arr;
        b.burst = len;
        b.start_priority = pr;
        pending_beats.push_back(b);
        beats_issued++;
    endtask

    task automatic push_ticks(input int count);
        repeat (count) push_beat(OP_TICK, 3'($urandom), 16'($urandom), 16'($urandom),
                                 8'($urandom));
    endtask

    task automatic load_slot(input logic [2:0] slot, input logic [15:0] arr,
                             input logic [15:0] len, input logic [7:0] pr);
        push_beat(OP_LOAD, slot, arr, len, pr);
    endtask

    task automatic settle();
        while (beats_taken != beats_issued || tick_reports.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [7:0] val);
        @(posedge clk);
        cfg_index <= idx;
        cfg_data <= val;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_PROCESS_COUNT)
            proc_count = val[3:0];
        else
            age_period = val;
    endtask

    task automatic queue_workload();
        int          n;
        int          i;
        int          step;
        int          ticks;
        int          len;
        int          pr;
        logic [15:0] arr;
        logic [15:0] first_arr;
        n = (proc_count == 4'd0) ? 1 : ((proc_count > 4'd8) ? SLOTS : int'(proc_count));
        case ($urandom_range(0, 3))
            0: arr = 16'd0;
            1: arr = 16'($urandom);
            2: arr = 16'hFFFF - 16'($urandom_range(0, 40));
            default: arr = 16'($urandom_range(0, 500));
        endcase
        first_arr = arr;
        ticks = 0;
        for (i = 0; i < n; i++)
        begin
            if (i > 0)
            begin
                step = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
                arr = (int'(arr) + step > 65535) ? 16'hFFFF : arr + 16'(step);
            end
            case ($urandom_range(0, 31))
                0: len = 0;
                1, 2: len = $urandom_range(1, 65535);
                default: len = $urandom_range(1, 6);
            endcase
            case ($urandom_range(0, 19))
                0: pr = 0;
                1, 2, 3, 4: pr = $urandom_range(1, 3);
                default: pr = $urandom_range(1, 255);
            endcase
            ticks += (len == 0 || len > 6) ? 6 : len;
            load_slot(3'(i), arr, 16'(len), 8'(pr));
        end
        ticks = ticks + int'(arr - first_arr) + $urandom_range(0, 3);
        push_ticks((ticks > 64) ? 64 : ticks);
    endtask

    task automatic queue_noise();
        repeat ($urandom_range(1, 6))
            push_beat(1'($urandom_range(0, 1)), 3'($urandom), 16'($urandom), 16'($urandom),
                      8'($urandom));
    endtask

    initial
    begin
        int         ph;
        int         quota;
        logic [3:0] cnt;
        logic [7:0] per;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        load_slot(3'd0, 16'd10, 16'd2, 8'd255);
        load_slot(3'd1, 16'd10, 16'd1, 8'd0);
        load_slot(3'd2, 16'd12, 16'd3, 8'd1);
        load_slot(3'd3, 16'hFFFF, 16'hFFFF, 8'd255);
        load_slot(3'd4, 16'hFFFF, 16'd0, 8'd0);
        load_slot(3'd5, 16'hFFFF, 16'd1, 8'd1);
        load_slot(3'd6, 16'hFFFF, 16'h5555, 8'hAA);
        load_slot(3'd7, 16'hFFFF, 16'hAAAA, 8'h55);
        push_ticks(8);
        settle();

        write_reg(CFG_PROCESS_COUNT, 8'd8);
        write_reg(CFG_AGING_PERIOD, 8'd1);
        load_slot(3'd0, 16'd0, 16'd1, 8'd1);
        load_slot(3'd1, 16'd3, 16'd0, 8'd255);
        load_slot(3'd2, 16'd3, 16'd1, 8'd2);
        push_ticks(6);
        settle();

        write_reg(CFG_PROCESS_COUNT, 8'd0);
        write_reg(CFG_AGING_PERIOD, 8'd255);
        push_ticks(2);
        settle();

        write_reg(CFG_PROCESS_COUNT, 8'd12);
        write_reg(CFG_AGING_PERIOD, 8'd0);
        push_ticks(2);

        for (ph = 0; ph < 8; ph++)
        begin
            settle();
            case (ph)
                0: begin cnt = 4'd8; per = 8'd1; end
                1: begin cnt = 4'd1; per = 8'd255; end
                2: begin cnt = 4'd8; per = 8'd2; end
                3: begin cnt = 4'($urandom_range(9, 15)); per = 8'd0; end
                default:
                begin
                    cnt = 4'($urandom_range(1, 8));
                    per = 8'($urandom_range(1, 12));
                end
            endcase
            write_reg(CFG_PROCESS_COUNT, {4'($urandom_range(0, 15)), cnt});
            write_reg(CFG_AGING_PERIOD, per);
            if (ph == 0 || ph == 4)
                hold_requests++;
            quota = beats_issued + 200;
            while (beats_issued < quota)
            begin
                if ($urandom_range(0, 9) == 0)
                    queue_noise();
                else
                    queue_workload();
            end
        end

        settle();
        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
